// ===== src/block_buffer_cache_lru_top_defines.svh =====
// ---------------------------------------------------------------------------
// Buffer cache assertion macros
// Shared assertion wrappers; ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define BBC_ASSERT_IMP(lbl, clk, rstn, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cons)) \
        else $error("bbc assertion failed");
`define BBC_ASSERT_NEXT(lbl, clk, rstn, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("bbc assertion failed");
`else
`define BBC_ASSERT_IMP(lbl, clk, rstn, trig, cons)
`define BBC_ASSERT_NEXT(lbl, clk, rstn, trig, cons)
`endif

`endif

// ===== src/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Buffer cache package
// Beat types, result kinds and controller/datapath command types.
// ---------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam logic [1:0] KIND_FETCH     = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] block_number;
        logic [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [15:0] out_block;
        logic [31:0] out_data;
        logic [2:0]  slot_index;
        logic        was_hit;
        logic        last_item;
    } out_item_t;

    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_ORDER,
        ADDR_SLOT
    } addr_sel_t;

    typedef struct packed {
        logic       accept;
        logic       ptr_clear;
        logic       ptr_inc;
        logic       ptr_dec;
        addr_sel_t  addr_sel;
        logic       slot_from_ptr;
        logic       slot_from_order;
        logic       set_vpos;
        logic       capture_hit;
        logic       assign_tag;
        logic       store_write;
        logic       fill_read;
        logic       clear_dirty;
        logic       move_victim;
        logic       emit;
        logic [1:0] kind;
    } bbc_cmd_t;

    typedef struct packed {
        logic tag_match;
        logic order_match;
        logic dirty_at;
        logic valid_at;
        logic ptr_last;
        logic ptr_zero;
        logic is_write;
        logic out_free;
    } bbc_status_t;

endpackage

`default_nettype wire

// ===== src/block_buffer_cache_lru_top.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache with LRU replacement, top level
// Fully associative delayed-write buffer cache: controller plus datapath.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          beat
//  s_       in   s_valid/s_ready    in_item_t  (mode, block_number, data_word)
//  m_       out  m_valid/m_ready    out_item_t (kind, block, data, slot, hit, last)
//
//  One request at a time: accept, tag search (up to NUM_BUFFERS slots), list
//  walk to the slot or first clean victim (up to NUM_BUFFERS entries), one
//  step per write-back beat, then the remaining states; the serial walk over
//  the slot tags and the LRU list dominates the time per request.
//  Reset is synchronous, active low; it empties the cache and sets the LRU
//  list to slots 0..NUM_BUFFERS-1. No clearing pass.
//  A single result register holds each beat; m_ready low stalls the
//  controller only in the states that emit a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lru_top #(
    parameter int NUM_BUFFERS = 8,
    parameter int TAG_BITS    = 16,
    parameter int DATA_BITS   = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  bbc_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  wire                m_ready,
    output bbc_pkg::out_item_t m_item
);
    import bbc_pkg::*;

    bbc_cmd_t    cmd;
    bbc_status_t st;

    // sequencer: search, scan, write-back and result states
    bbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // slot arrays, LRU list and result register
    bbc_dpath #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .TAG_BITS    (TAG_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

// ===== src/bbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Buffer cache controller
// Sequences search, victim scan, write-backs and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  bbc_pkg::bbc_status_t st,
    output bbc_pkg::bbc_cmd_t    cmd
);
    import bbc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINDPOS,
        ST_SCAN,
        ST_WBALL,
        ST_VICTIM,
        ST_ASSIGN,
        ST_ACT,
        ST_WB,
        ST_MOVE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   wb_reg, wb_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.addr_sel = ADDR_SLOT;
        state_next = state_reg;
        wb_next    = wb_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.addr_sel = ADDR_PTR;
                if (st.tag_match) begin
                    cmd.slot_from_ptr = 1'b1;
                    cmd.ptr_clear     = 1'b1;
                    state_next        = ST_FINDPOS;
                end else if (st.ptr_last) begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_FINDPOS: begin
                if (st.order_match) begin
                    cmd.set_vpos    = 1'b1;
                    cmd.capture_hit = 1'b1;
                    wb_next         = 1'b0;
                    state_next      = ST_ACT;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SCAN: begin
                cmd.addr_sel = ADDR_ORDER;
                if (!st.dirty_at) begin
                    cmd.slot_from_order = 1'b1;
                    cmd.set_vpos        = 1'b1;
                    cmd.ptr_dec         = 1'b1;
                    wb_next             = !st.ptr_zero;
                    state_next          = ST_ASSIGN;
                end else if (st.ptr_last) begin
                    state_next = ST_WBALL;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_WBALL: begin
                cmd.addr_sel = ADDR_ORDER;
                if (st.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.kind        = KIND_WRITEBACK;
                    cmd.clear_dirty = 1'b1;
                    if (st.ptr_zero) state_next = ST_VICTIM;
                    else cmd.ptr_dec = 1'b1;
                end
            end
            ST_VICTIM: begin
                cmd.addr_sel        = ADDR_ORDER;
                cmd.slot_from_order = 1'b1;
                cmd.set_vpos        = 1'b1;
                wb_next             = 1'b0;
                state_next          = ST_ASSIGN;
            end
            ST_ASSIGN: begin
                cmd.assign_tag = 1'b1;
                state_next     = ST_ACT;
            end
            ST_ACT: begin
                if (st.is_write) begin
                    cmd.store_write = 1'b1;
                    state_next      = wb_reg ? ST_WB : ST_MOVE;
                end else if (!st.valid_at) begin
                    if (st.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.kind      = KIND_FETCH;
                        cmd.fill_read = 1'b1;
                        state_next    = wb_reg ? ST_WB : ST_MOVE;
                    end
                end else begin
                    state_next = wb_reg ? ST_WB : ST_MOVE;
                end
            end
            ST_WB: begin
                cmd.addr_sel = ADDR_ORDER;
                if (st.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.kind        = KIND_WRITEBACK;
                    cmd.clear_dirty = 1'b1;
                    if (st.ptr_zero) state_next = ST_MOVE;
                    else cmd.ptr_dec = 1'b1;
                end
            end
            ST_MOVE: begin
                cmd.move_victim = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wb_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wb_reg    <= wb_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bbc_dpath.sv =====
// ---------------------------------------------------------------------------
// Buffer cache datapath
// Slot tags, flags, data words, LRU list, pointers and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "block_buffer_cache_lru_top_defines.svh"

module bbc_dpath #(
    parameter int NUM_BUFFERS = 8,
    parameter int TAG_BITS    = 16,
    parameter int DATA_BITS   = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  bbc_pkg::in_item_t    s_item,
    input  bbc_pkg::bbc_cmd_t    cmd,
    output bbc_pkg::bbc_status_t st,
    output logic                 m_valid,
    input  wire                  m_ready,
    output bbc_pkg::out_item_t   m_item
);
    import bbc_pkg::*;

    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    logic [TAG_BITS-1:0]  tag_reg   [NUM_BUFFERS];
    logic                 inuse_reg [NUM_BUFFERS];
    logic                 valid_reg [NUM_BUFFERS];
    logic                 dirty_reg [NUM_BUFFERS];
    logic [DATA_BITS-1:0] data_reg  [NUM_BUFFERS];
    logic [IDX_W-1:0]     order_reg [NUM_BUFFERS];

    logic                 write_reg;
    logic [TAG_BITS-1:0]  blk_reg;
    logic [DATA_BITS-1:0] wdata_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     ptr_reg, slot_reg, vpos_reg;

    logic                 m_valid_reg;
    out_item_t            m_item_reg;

    logic [IDX_W-1:0]     a;
    logic [IDX_W-1:0]     order_at_ptr;
    out_item_t            item;

    assign order_at_ptr = order_reg[ptr_reg];

    always_comb begin
        unique case (cmd.addr_sel)
            ADDR_PTR:   a = ptr_reg;
            ADDR_ORDER: a = order_at_ptr;
            ADDR_SLOT:  a = slot_reg;
            default:    a = slot_reg;
        endcase
    end

    assign st.tag_match   = inuse_reg[a] && (tag_reg[a] == blk_reg);
    assign st.order_match = (order_at_ptr == slot_reg);
    assign st.dirty_at    = dirty_reg[a];
    assign st.valid_at    = valid_reg[a];
    assign st.ptr_last    = (ptr_reg == IDX_W'(NUM_BUFFERS - 1));
    assign st.ptr_zero    = (ptr_reg == '0);
    assign st.is_write    = write_reg;
    assign st.out_free    = !m_valid_reg || m_ready;

    // result beat assembly
    always_comb begin
        item              = '0;
        item.command_kind = cmd.kind;
        item.slot_index   = 3'(a);
        item.out_block    = 16'(blk_reg);
        if (cmd.kind == KIND_WRITEBACK) begin
            item.out_block = 16'(tag_reg[a]);
            item.out_data  = 32'(data_reg[a]);
        end else if (cmd.kind == KIND_DONE) begin
            item.was_hit   = hit_reg;
            item.last_item = 1'b1;
            if (!write_reg) item.out_data = 32'(data_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                tag_reg[i]   <= '0;
                inuse_reg[i] <= 1'b0;
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                order_reg[i] <= IDX_W'(i);
            end
            ptr_reg     <= '0;
            slot_reg    <= '0;
            vpos_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                ptr_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.ptr_clear) ptr_reg <= '0;
            if (cmd.ptr_inc)   ptr_reg <= ptr_reg + 1'b1;
            if (cmd.ptr_dec)   ptr_reg <= ptr_reg - 1'b1;
            if (cmd.slot_from_ptr)   slot_reg <= ptr_reg;
            if (cmd.slot_from_order) slot_reg <= order_at_ptr;
            if (cmd.set_vpos)        vpos_reg <= ptr_reg;
            if (cmd.capture_hit)     hit_reg  <= valid_reg[slot_reg];
            if (cmd.assign_tag) begin
                tag_reg[a]   <= blk_reg;
                inuse_reg[a] <= 1'b1;
                valid_reg[a] <= 1'b0;
            end
            if (cmd.store_write) begin
                dirty_reg[a] <= 1'b1;
                valid_reg[a] <= 1'b1;
            end
            if (cmd.fill_read)   valid_reg[a] <= 1'b1;
            if (cmd.clear_dirty) dirty_reg[a] <= 1'b0;
            // pull the used slot out of the list and put it at the MRU tail
            if (cmd.move_victim) begin
                for (int i = 0; i < NUM_BUFFERS - 1; i++) begin
                    if (IDX_W'(i) >= vpos_reg) order_reg[i] <= order_reg[i + 1];
                end
                order_reg[NUM_BUFFERS - 1] <= slot_reg;
            end
            if (cmd.emit)         m_valid_reg <= 1'b1;
            else if (m_ready)     m_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            write_reg <= s_item.mode;
            blk_reg   <= TAG_BITS'(s_item.block_number);
            wdata_reg <= DATA_BITS'(s_item.data_word);
        end
        if (cmd.store_write || cmd.fill_read) data_reg[a] <= wdata_reg;
        if (cmd.emit) m_item_reg <= item;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `BBC_ASSERT_IMP(a_victim_clean, aclk, aresetn, cmd.assign_tag, !dirty_reg[a])
    `BBC_ASSERT_IMP(a_emit_room, aclk, aresetn, cmd.emit, !m_valid_reg || m_ready)
    `BBC_ASSERT_IMP(a_last_is_done, aclk, aresetn, m_valid_reg,
                    m_item_reg.last_item == (m_item_reg.command_kind == KIND_DONE))
    `BBC_ASSERT_NEXT(a_wb_clears, aclk, aresetn, cmd.clear_dirty, !dirty_reg[$past(a)])

endmodule

`default_nettype wire
